### design/assert_macros.svh
// Assertion macros used by the sample smoothing filter.
// Assumes a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### design/ssf_pkg.sv
// Shared types and constants of the sample smoothing filter.
// No dependencies.
package ssf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W     = 1;
	localparam int WIN_W      = 6;
	localparam int ALPHA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_EMA = 1'b0;
	localparam logic [MODE_W-1:0] MODE_AVG = 1'b1;

	localparam logic [MODE_W-1:0]  MODE_RST   = MODE_AVG;
	localparam logic [WIN_W-1:0]   WINDOW_RST = 6'd16;
	localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd16384;

	// Q15 unity weight and rounding half.
	localparam logic [ALPHA_W:0] ALPHA_ONE = 17'd32768;
	localparam int Q15_SHIFT = 15;
	localparam int Q15_HALF  = 16384;

endpackage

### design/ssf_in_if.sv
// Input channel of the sample smoothing filter: one sample and its record flag.
// No dependencies.
interface ssf_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          record_start;

	modport source (output valid, output sample_in, output record_start, input ready);
	modport sink (input valid, input sample_in, input record_start, output ready);
endinterface

### design/ssf_out_if.sv
// Output channel of the sample smoothing filter: one smoothed sample.
// No dependencies.
interface ssf_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] smoothed_out;

	modport source (output valid, output smoothed_out, input ready);
	modport sink (input valid, input smoothed_out, output ready);
endinterface

### design/sample_smoothing_filter.sv
// Sample smoothing filter: moving average or Q15 exponential smoother.
// Depends on ssf_pkg, ssf_in_if, ssf_out_if and assert_macros.svh.
//
// Usage: samples enter on sample_ch (valid/ready); each beat carries a signed
// sample and a record_start flag that clears the history. Every input beat
// yields exactly one beat on result_ch. mode_q selects the moving average (1)
// or the exponential smoother (0); both track every sample, so the mode may
// change between items. Registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle, a duty of the user that the block itself
// does not enforce; writes to unknown indexes are dropped.
// Timing: one item at a time. After acceptance the block sums the newest
// min(seen, window) samples from the history RAM, one read per cycle, then a
// restoring divider produces the rounded average one quotient bit per cycle.
//
// Reset clears the controls and the registers to their defaults; the first
// sample after reset starts a record. A result waits in the output register
// while result_ch stalls; the next input beat is still accepted and processed,
// and its result is held back until the output register frees up.

`include "assert_macros.svh"

module sample_smoothing_filter #(
	parameter int WINDOW_MAX  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ssf_in_if.sink                              sample_ch,
	ssf_out_if.source                           result_ch,
	input  logic                                cfg_we,
	input  logic [ssf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int WV_W   = (CNT_W > ssf_pkg::WIN_W) ? CNT_W : ssf_pkg::WIN_W;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int NUM_W  = SUM_W + 1;
	localparam int DEN_W  = CNT_W + 1;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + ssf_pkg::ALPHA_W + 2;
	localparam int RND_W  = PROD_W - ssf_pkg::Q15_SHIFT;
	localparam int EMA_W  = RND_W + 1;

	localparam logic [CNT_W-1:0]  WMAX_C   = CNT_W'(WINDOW_MAX);
	localparam logic [WV_W-1:0]   WMAX_V   = WV_W'(WINDOW_MAX);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_MAX - 1);
	localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(NUM_W);

	// Configuration registers
	logic [ssf_pkg::MODE_W-1:0]  mode_q;
	logic [ssf_pkg::WIN_W-1:0]   window_q;
	logic [ssf_pkg::ALPHA_W-1:0] alpha_q;

	// Control state
	ssf_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  seen_q;
	logic [PTR_W-1:0]  slot_q;
	logic [CNT_W-1:0]  rd_left_q;
	logic              rd_vld_s1;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              out_valid_q;

	// Datapath registers
	logic signed [SAMPLE_BITS-1:0] hist_mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] rd_data_s1;
	logic [PTR_W-1:0]              ptr_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          first_q;
	logic [CNT_W-1:0]              n_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          neg_q;
	logic [NUM_W-1:0]              num_q;
	logic [DEN_W-1:0]              den_q;
	logic [DEN_W-1:0]              rem_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	// Combinational signals
	logic                          accept;
	logic                          rd_en;
	logic                          reads_idle;
	logic                          sum_done;
	logic                          div_en;
	logic                          load_out;
	logic                          first;
	logic [CNT_W-1:0]              seen_base;
	logic [CNT_W-1:0]              seen_new;
	logic [PTR_W-1:0]              slot_base;
	logic [PTR_W-1:0]              slot_new;
	logic [WV_W-1:0]               win_ext;
	logic [WV_W-1:0]               win_clamp;
	logic [CNT_W-1:0]              n_new;
	logic [SUM_W-1:0]              sum_mag;
	logic [DEN_W:0]                rem_sh;
	logic                          q_bit;
	logic [DEN_W:0]                rem_sub;
	logic [SAMPLE_BITS-1:0]        q_mag;
	logic signed [SAMPLE_BITS-1:0] avg;
	logic [ssf_pkg::ALPHA_W:0]     alpha_sat;
	logic                          prod_neg;
	logic [PROD_W-1:0]             prod_mag;
	logic [PROD_W-1:0]             prod_rnd;
	logic signed [EMA_W-1:0]       rnd_signed;
	logic signed [EMA_W-1:0]       ema_full;
	logic signed [SAMPLE_BITS-1:0] ema;

	// ---------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ssf_pkg::MODE_RST;
			window_q <= ssf_pkg::WINDOW_RST;
			alpha_q  <= ssf_pkg::ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ssf_pkg::CFG_MODE:   mode_q   <= cfg_data[ssf_pkg::MODE_W-1:0];
				ssf_pkg::CFG_WINDOW: window_q <= cfg_data[ssf_pkg::WIN_W-1:0];
				ssf_pkg::CFG_ALPHA:  alpha_q  <= cfg_data[ssf_pkg::ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Record bookkeeping for the arriving sample
	// ---------------------------------------------------------------
	always_comb begin
		first     = sample_ch.record_start || (seen_q == '0);
		seen_base = first ? '0 : seen_q;
		slot_base = first ? '0 : slot_q;
		seen_new  = (seen_base < WMAX_C) ? seen_base + 1'b1 : seen_base;
		slot_new  = (slot_base == PTR_LAST) ? '0 : slot_base + 1'b1;
		// Clamp the window to 1..WINDOW_MAX.
		win_ext   = WV_W'(window_q);
		win_clamp = win_ext;
		if (win_ext == '0)
			win_clamp = WV_W'(1);
		else if (win_ext > WMAX_V)
			win_clamp = WMAX_V;
		n_new = (WV_W'(seen_new) < win_clamp) ? seen_new : CNT_W'(win_clamp);
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ssf_pkg::ST_IDLE);
	assign reads_idle = !rd_vld_s1 && (rd_left_q == '0);

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		sum_done = 1'b0;
		div_en   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ssf_pkg::ST_IDLE: begin
				if (sample_ch.valid)
					state_d = ssf_pkg::ST_SUM;
			end
			ssf_pkg::ST_SUM: begin
				rd_en = (rd_left_q != '0);
				if (rd_left_q == '0 && !rd_vld_s1) begin
					sum_done = 1'b1;
					state_d  = ssf_pkg::ST_DIV;
				end
			end
			ssf_pkg::ST_DIV: begin
				div_en = 1'b1;
				if (div_cnt_q == DCNT_W'(1))
					state_d = ssf_pkg::ST_DONE;
			end
			ssf_pkg::ST_DONE: begin
				if (!out_valid_q || result_ch.ready) begin
					load_out = 1'b1;
					state_d  = ssf_pkg::ST_IDLE;
				end
			end
			default: state_d = ssf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------------------------------------------------------
	// History RAM: write the new sample, read older ones back
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept)
			hist_mem[slot_base] <= sample_ch.sample_in;
		if (rd_en)
			rd_data_s1 <= hist_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			slot_q    <= '0;
			rd_left_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (accept) begin
				seen_q    <= seen_new;
				slot_q    <= slot_new;
				rd_left_q <= n_new - 1'b1;
			end else if (rd_en) begin
				rd_left_q <= rd_left_q - 1'b1;
			end
		end
	end

	// Running sum: start with the new sample, add each read as it returns.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= sample_ch.sample_in;
			first_q <= first;
			n_q     <= n_new;
			sum_q   <= SUM_W'(sample_ch.sample_in);
			diff_q  <= DIFF_W'(sample_ch.sample_in) - DIFF_W'(prev_q);
			// Newest-first walk backwards from the slot just written.
			ptr_q   <= (slot_base == '0) ? PTR_LAST : slot_base - 1'b1;
		end else begin
			if (rd_en)
				ptr_q <= (ptr_q == '0) ? PTR_LAST : ptr_q - 1'b1;
			if (rd_vld_s1)
				sum_q <= sum_q + SUM_W'(rd_data_s1);
		end
	end

	// ---------------------------------------------------------------
	// Rounded average: (2|sum| + n) / 2n, one quotient bit per cycle
	// ---------------------------------------------------------------
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (sum_done)
			div_cnt_q <= DIV_STEPS;
		else if (div_en)
			div_cnt_q <= div_cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (sum_done) begin
			neg_q <= sum_q[SUM_W-1];
			num_q <= {sum_mag, 1'b0} + NUM_W'(n_q);
			den_q <= {n_q, 1'b0};
			rem_q <= '0;
		end else if (div_en) begin
			num_q <= {num_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign q_mag = num_q[SAMPLE_BITS-1:0];
	assign avg   = neg_q ? -$signed(q_mag) : $signed(q_mag);

	// ---------------------------------------------------------------
	// Exponential smoother: y + round(alpha * (x - y) / 2^15)
	// ---------------------------------------------------------------
	assign alpha_sat = ({1'b0, alpha_q} > ssf_pkg::ALPHA_ONE) ? ssf_pkg::ALPHA_ONE
		: {1'b0, alpha_q};

	always_ff @(posedge clk) begin
		if (state_q == ssf_pkg::ST_SUM)
			prod_q <= PROD_W'($signed({1'b0, alpha_sat})) * PROD_W'(diff_q);
	end

	always_comb begin
		prod_neg   = prod_q[PROD_W-1];
		prod_mag   = prod_neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		prod_rnd   = prod_mag + PROD_W'(ssf_pkg::Q15_HALF);
		rnd_signed = $signed(EMA_W'(prod_rnd[PROD_W-1:ssf_pkg::Q15_SHIFT]));
		if (prod_neg)
			rnd_signed = -rnd_signed;
		ema_full = EMA_W'(prev_q) + rnd_signed;
		ema      = first_q ? x_q : ema_full[SAMPLE_BITS-1:0];
	end

	// ---------------------------------------------------------------
	// Output register and smoother state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_q      <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			prev_q      <= ema;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= (mode_q == ssf_pkg::MODE_AVG) ? avg : ema;
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.smoothed_out = out_data_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASSERT_CLK(a_accept_starts_sum, accept |=> (state_q == ssf_pkg::ST_SUM), "no sum after beat")
	`ASSERT_NEVER(a_seen_bound, seen_q > WMAX_C, "sample count above window capacity")
	`ASSERT_CLK(a_div_after_reads, (state_q == ssf_pkg::ST_DIV) |-> reads_idle, "reads pending")
	`ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(load_out), "stray result beat")

endmodule

### test/tb_sample_smoothing_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for sample_smoothing_filter: moving average and Q15 smoother.
// Depends on ssf_pkg, ssf_in_if, ssf_out_if and the sample_smoothing_filter RTL.
module tb_sample_smoothing_filter;
	import ssf_pkg::*;

	localparam int SMP_W        = 16;
	localparam int WIN_MAX      = 32;
	localparam int CYCLE_LIMIT  = 1000000;
	// Idle tail after the last result.
	localparam int QUIET_CYCLES = 80;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 127;
	localparam int REPORT_MAX   = 10;
	// Index with no register behind it; the block drops such writes.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	typedef struct {
		logic signed [SMP_W-1:0] sample;
		logic                    rs;
	} sample_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ssf_in_if  #(.SAMPLE_BITS(SMP_W)) sample_ch ();
	ssf_out_if #(.SAMPLE_BITS(SMP_W)) result_ch ();

	sample_smoothing_filter #(
		.WINDOW_MAX (WIN_MAX),
		.SAMPLE_BITS(SMP_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Samples waiting to be driven, and smoothed values waiting to come out.
	sample_beat_t            sample_backlog[$];
	logic signed [SMP_W-1:0] expected_smoothed[$];

	// Register shadows, updated as the writes are issued (block is idle then).
	logic [MODE_W-1:0]  mode_r;
	logic [WIN_W-1:0]   win_r;
	logic [ALPHA_W-1:0] alpha_r;

	// Filter history as the block should hold it.
	logic signed [SMP_W-1:0] hist[WIN_MAX];
	int unsigned             seen_cnt;
	int unsigned             slot;
	logic signed [SMP_W-1:0] last_ema;

	int  send_idle_pct;
	int  recv_stall_pct;
	int  restart_odds;
	bit  beat_live;
	bit  in_taken;
	int  errors;
	int  cycle_count;

	// Advance both smoothers by one sample and return what the selected mode gives.
	function automatic logic signed [SMP_W-1:0] smooth_sample(
		input logic signed [SMP_W-1:0] x,
		input logic                    rs
	);
		bit          first;
		int unsigned w;
		int unsigned n;
		longint      acc;
		longint      mag;
		longint      q;
		longint      avg;
		longint      ema;
		longint      a;
		longint      prod;
		first = rs || (seen_cnt == 0);
		if (first) begin
			seen_cnt = 0;
			slot = 0;
		end
		hist[slot] = x;
		slot = (slot + 1) % WIN_MAX;
		if (seen_cnt < WIN_MAX)
			seen_cnt++;
		// Window zero acts as one, anything past the ring saturates.
		w = win_r;
		if (w < 1)
			w = 1;
		if (w > WIN_MAX)
			w = WIN_MAX;
		n = (seen_cnt < w) ? seen_cnt : w;
		acc = 0;
		for (int unsigned k = 0; k < n; k++)
			acc += longint'(hist[(slot + WIN_MAX - 1 - k) % WIN_MAX]);
		// Round to nearest, ties away from zero.
		mag = (acc < 0) ? -acc : acc;
		q = (2 * mag + longint'(n)) / (2 * longint'(n));
		avg = (acc < 0) ? -q : q;
		if (first) begin
			ema = longint'(x);
		end else begin
			a = (alpha_r > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_r);
			prod = a * (longint'(x) - longint'(last_ema));
			mag = (prod < 0) ? -prod : prod;
			q = (mag + Q15_HALF) >>> Q15_SHIFT;
			ema = longint'(last_ema) + ((prod < 0) ? -q : q);
		end
		last_ema = ema[SMP_W-1:0];
		return (mode_r == MODE_AVG) ? avg[SMP_W-1:0] : ema[SMP_W-1:0];
	endfunction

	task automatic note_failure(input string what, input logic signed [SMP_W-1:0] want,
			input logic signed [SMP_W-1:0] got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
	endtask

	// Accept input beats into the predictor and check result beats, all at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_smoothed.push_back(smooth_sample(sample_ch.sample_in,
					sample_ch.record_start));
				in_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_smoothed.size() == 0)
					note_failure("result with nothing pending", '0, result_ch.smoothed_out);
				else if (result_ch.smoothed_out !== expected_smoothed[0])
					note_failure("smoothed_out mismatch", expected_smoothed.pop_front(),
						result_ch.smoothed_out);
				else
					void'(expected_smoothed.pop_front());
			end
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_sample_smoothing_filter NOT OK");
			$finish;
		end
	end

	// Sample driver: hold a beat until it is taken, then maybe idle before the next one.
	always @(negedge clk) begin
		bit busy;
		sample_beat_t nxt;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			beat_live = 1'b0;
		end else begin
			busy = beat_live && !in_taken;
			if (!busy && sample_backlog.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = sample_backlog.pop_front();
				sample_ch.sample_in    <= nxt.sample;
				sample_ch.record_start <= nxt.rs;
				busy = 1'b1;
			end
			sample_ch.valid <= busy;
			beat_live = busy;
		end
		in_taken = 1'b0;
	end

	// Result sink: stall at random per the current phase.
	always @(negedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_beat(input logic signed [SMP_W-1:0] s, input logic rs);
		sample_beat_t b;
		b.sample = s;
		b.rs = rs;
		sample_backlog.push_back(b);
	endtask

	// Hold the sender until every expected result is out, then let the block go quiet.
	task automatic wait_idle();
		while (sample_backlog.size() != 0 || beat_live || expected_smoothed.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_MODE:   mode_r = val[MODE_W-1:0];
			CFG_WINDOW: win_r = val[WIN_W-1:0];
			CFG_ALPHA:  alpha_r = val[ALPHA_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly full-range values, with the rails and a band near zero for rounding ties.
	function automatic logic signed [SMP_W-1:0] draw_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return SMP_W'($urandom_range(16) - 8);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_window();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd2;
			3: return 16'd32;
			4: return 16'd33;
			5: return 16'd63;
			default: return CFG_DATA_W'($urandom_range(63));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_alpha();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd32767;
			3: return 16'd32768;
			4: return 16'd32769;
			5: return 16'hFFFF;
			default: return CFG_DATA_W'($urandom_range(65535));
		endcase
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] win_val;
		logic [CFG_DATA_W-1:0] alpha_val;
		logic [CFG_DATA_W-1:0] mode_val;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_in = '0;
		sample_ch.record_start = 1'b0;
		result_ch.ready = 1'b0;
		mode_r = MODE_RST;
		win_r = WINDOW_RST;
		alpha_r = ALPHA_RST;
		seen_cnt = 0;
		slot = 0;
		last_ema = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		cycle_count = 0;
		beat_live = 1'b0;
		in_taken = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: the first sample opens a record even without the flag.
		push_beat(16'sh7FFF, 1'b0);
		push_beat(16'sh7FFF, 1'b0);
		push_beat(16'sh8000, 1'b0);
		// Half-way averages must round away from zero in both directions.
		push_beat(-16'sd1, 1'b1);
		push_beat(16'sd0, 1'b0);
		push_beat(16'sd1, 1'b1);
		push_beat(16'sd0, 1'b0);
		wait_idle();

		// Window zero behaves as a window of one.
		write_reg(CFG_WINDOW, 16'd0);
		push_beat(16'sh8000, 1'b0);
		push_beat(16'sd12345, 1'b0);
		wait_idle();

		// Oversized window saturates; the change lands mid-record.
		write_reg(CFG_WINDOW, 16'd63);
		push_beat(16'sd7, 1'b0);
		wait_idle();

		// Switch to the smoother mid-record with a weight above one.
		write_reg(CFG_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_EMA});
		write_reg(CFG_ALPHA, 16'hFFFF);
		push_beat(16'sh8000, 1'b0);
		push_beat(16'sh7FFF, 1'b0);
		wait_idle();

		// Zero weight: output holds.
		write_reg(CFG_ALPHA, 16'd0);
		push_beat(16'sd100, 1'b0);
		push_beat(-16'sd100, 1'b0);
		wait_idle();

		// Unity weight and full ring; a new record passes straight through.
		write_reg(CFG_ALPHA, 16'd32768);
		write_reg(CFG_WINDOW, 16'd32);
		push_beat(16'sh7FFF, 1'b0);
		push_beat(16'sh8000, 1'b1);
		wait_idle();

		write_reg(CFG_ALPHA, 16'd1);
		push_beat(16'sh7FFF, 1'b0);
		push_beat(16'sd3, 1'b0);
		wait_idle();

		// Unmapped index must not disturb anything; back to the average.
		write_reg(CFG_UNMAPPED, 16'hFFFF);
		write_reg(CFG_ALPHA, 16'd16385);
		write_reg(CFG_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_AVG});
		write_reg(CFG_WINDOW, 16'd2);
		push_beat(-16'sd3, 1'b0);
		push_beat(16'sd2, 1'b0);
		push_beat(16'sh7FFF, 1'b1);
		push_beat(16'sh7FFF, 1'b0);
		wait_idle();

		// Random phases. Records mostly run long enough to fill the ring and
		// carry across phase boundaries, so each new setting lands mid-record.
		for (int p = 0; p < RAND_PHASES; p++) begin
			mode_val  = CFG_DATA_W'($urandom_range(1));
			win_val   = pick_window();
			alpha_val = pick_alpha();
			// Pin the extremes early so they never depend on luck.
			case (p)
				0: begin
					mode_val = {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_AVG};
					win_val = 16'd32;
				end
				1: begin
					mode_val = {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_EMA};
					alpha_val = 16'd32768;
				end
				2: begin
					mode_val = {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_AVG};
					win_val = 16'd1;
				end
				3: begin
					mode_val = {{(CFG_DATA_W-MODE_W){1'b0}}, MODE_EMA};
					alpha_val = 16'd0;
				end
				default: ;
			endcase
			write_reg(CFG_MODE, mode_val);
			write_reg(CFG_WINDOW, win_val);
			write_reg(CFG_ALPHA, alpha_val);

			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			// Every third phase uses short records to exercise partial windows.
			restart_odds = (p % 3 == 2) ? 6 : 48;

			for (int i = 0; i < PHASE_ITEMS; i++)
				push_beat(draw_sample(), $urandom_range(restart_odds - 1) == 0);
			wait_idle();
		end

		if (expected_smoothed.size() != 0)
			note_failure("results never arrived", expected_smoothed[0], '0);
		if (errors == 0)
			$display("tb_sample_smoothing_filter OK");
		else
			$display("tb_sample_smoothing_filter NOT OK");
		$finish;
	end

endmodule
